// ----- rtl/tle_pkg.sv -----
// Shared command types, op codes and character constants for the TTY line editor.
`default_nettype none

package tle_pkg;

    // command op codes, front to back
    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_DEL  = 3'd1;
    localparam logic [2:0] OP_CR   = 3'd2;
    localparam logic [2:0] OP_LF   = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [7:0] CHAR_DEL = 8'h7F;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    localparam logic [6:0] MAX_READ = 7'd64;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] count;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tty_line_editor_top.sv -----
// Top level of the TTY line editor: front classifier, command queue and back engine.
// Path: a word accepted on s_axis is written into the queue, decoded out of it by the
//   back engine into its state and sequence registers, and then loaded into the
//   output register when the output is free.
// Flow: the back engine takes a new word only from idle and emits echo bytes one by one;
//   a read alternates an address state and a data state per byte, as the ring read data
//   is registered; the front keeps accepting while the 2-entry queue has room.
// Reset: rst_n clears pointers, counts, queue and output valid at once; ring memory
//   contents are left as they are and are only read after being written.
`default_nettype none

module tty_line_editor_top #(
    parameter int LINE_BYTES = 1024,
    parameter int RING_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] char_in, [14:8] read_count, [15] zero
    input  wire logic        s_axis_tuser,   // [0] action: 0 character, 1 read
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]       m_axis_tuser,   // [1:0] kind: echo, read data, empty read
    output logic             m_axis_tlast    // last result word of an input word
);

    tle_pkg::cmd_t front_cmd;
    tle_pkg::cmd_t queue_cmd;
    logic          front_push;
    logic          queue_full;
    logic          queue_valid;
    logic          queue_pop;

    // classify characters (DEL, CR, LF, plain) and reads; saturate read count
    tle_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_full   (queue_full),
        .q_push   (front_push),
        .q_cmd    (front_cmd)
    );

    // short queue lets input and output stall independently
    tle_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .cmd_in  (front_cmd),
        .full    (queue_full),
        .pop     (queue_pop),
        .valid   (queue_valid),
        .cmd_out (queue_cmd)
    );

    // line state, ring store and result sequencing
    tle_back #(
        .LINE_BYTES (LINE_BYTES),
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (queue_valid),
        .q_cmd    (queue_cmd),
        .q_pop    (queue_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/tle_front.sv -----
// Input side: accepts stream words and classifies them into editor commands.
`default_nettype none

module tle_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [15:0]   s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          q_full,
    output logic               q_push,
    output tle_pkg::cmd_t      q_cmd
);

    logic [7:0] ch;
    logic [6:0] cnt;

    assign ch       = s_tdata[7:0];
    assign cnt      = s_tdata[14:8];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_cmd.ch    = ch;
        q_cmd.count = (cnt > tle_pkg::MAX_READ) ? tle_pkg::MAX_READ : cnt;
        if (s_tuser)
        begin
            q_cmd.op = tle_pkg::OP_READ;
        end
        else
        begin
            unique case (ch)
                tle_pkg::CHAR_DEL: q_cmd.op = tle_pkg::OP_DEL;
                tle_pkg::CHAR_CR:  q_cmd.op = tle_pkg::OP_CR;
                tle_pkg::CHAR_LF:  q_cmd.op = tle_pkg::OP_LF;
                default:           q_cmd.op = tle_pkg::OP_CHAR;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tle_cmd_queue.sv -----
// Two-entry command queue between the front and back parts.
`default_nettype none

module tle_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tle_pkg::cmd_t      cmd_in,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output tle_pkg::cmd_t      cmd_out
);

    tle_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign cmd_out = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tle_back.sv -----
// Execution side: line state, ring memory, echo sequencing and read draining.
`default_nettype none

module tle_back #(
    parameter int LINE_BYTES = 1024,
    parameter int RING_BYTES = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  tle_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    localparam int AW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int CW = $clog2(RING_BYTES + 1);
    localparam int EW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int SW = CW + 2;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ECHO    = 2'd1;
    localparam logic [1:0] ST_RD_ADDR = 2'd2;
    localparam logic [1:0] ST_RD_DATA = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [EW-1:0] el_reg, el_next;
    logic [23:0]   seq_reg, seq_next;
    logic [1:0]    seq_left_reg, seq_left_next;
    logic [1:0]    seq_kind_reg, seq_kind_next;
    logic [6:0]    rd_left_reg, rd_left_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    ring_mem [RING_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we, mem_re;
    logic [7:0]    mem_wdata;

    logic          out_free;
    logic [CW:0]   fill;
    logic          room_nl, room_char;
    logic [AW-1:0] tail_inc, tail_dec, rp_inc;
    logic [SW-1:0] pos_sum;

    assign out_free = !out_valid_reg || m_tready;
    assign fill     = {1'b0, cc_reg} + (CW+1)'(el_reg);
    assign room_nl  = fill < (CW+1)'(RING_BYTES);
    assign room_char = ((EW+1)'(el_reg) + (EW+1)'(1) < (EW+1)'(LINE_BYTES))
                    && (fill + (CW+1)'(1) < (CW+1)'(RING_BYTES));
    assign tail_inc = (tail_reg == AW'(RING_BYTES - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? AW'(RING_BYTES - 1) : tail_reg - AW'(1);
    assign rp_inc   = (rp_reg == AW'(RING_BYTES - 1)) ? '0 : rp_reg + AW'(1);
    assign pos_sum  = SW'(rp_reg) + SW'(cc_reg) + SW'(el_reg);

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        tail_next      = tail_reg;
        cc_next        = cc_reg;
        el_next        = el_reg;
        seq_next       = seq_reg;
        seq_left_next  = seq_left_reg;
        seq_kind_next  = seq_kind_reg;
        rd_left_next   = rd_left_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = q_cmd.ch;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    seq_kind_next = tle_pkg::KIND_ECHO;
                    unique case (q_cmd.op)
                        tle_pkg::OP_DEL:
                        begin
                            if (el_reg != '0)
                            begin
                                el_next       = el_reg - EW'(1);
                                tail_next     = tail_dec;
                                seq_next      = {tle_pkg::CHAR_BS, tle_pkg::CHAR_SP,
                                                 tle_pkg::CHAR_BS};
                                seq_left_next = 2'd3;
                                state_next    = ST_ECHO;
                            end
                        end
                        tle_pkg::OP_CR, tle_pkg::OP_LF:
                        begin
                            if (q_cmd.op == tle_pkg::OP_CR)
                            begin
                                seq_next      = {8'h00, tle_pkg::CHAR_LF, tle_pkg::CHAR_CR};
                                seq_left_next = 2'd2;
                            end
                            else
                            begin
                                seq_next      = {16'h0000, tle_pkg::CHAR_LF};
                                seq_left_next = 2'd1;
                            end
                            state_next = ST_ECHO;
                            // a completely full ring still echoes but stores nothing
                            if (room_nl)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = tle_pkg::CHAR_LF;
                                cc_next   = fill[CW-1:0] + CW'(1);
                                el_next   = '0;
                                tail_next = tail_inc;
                            end
                        end
                        tle_pkg::OP_READ:
                        begin
                            if (cc_reg == '0 || q_cmd.count == 7'd0)
                            begin
                                seq_kind_next = tle_pkg::KIND_EMPTY;
                                seq_next      = 24'h000000;
                                seq_left_next = 2'd1;
                                state_next    = ST_ECHO;
                            end
                            else
                            begin
                                rd_left_next = (CW'(q_cmd.count) < cc_reg) ? q_cmd.count
                                                                           : cc_reg[6:0];
                                state_next   = ST_RD_ADDR;
                            end
                        end
                        default:
                        begin
                            if (room_char)
                            begin
                                mem_we        = 1'b1;
                                el_next       = el_reg + EW'(1);
                                tail_next     = tail_inc;
                                seq_next      = {16'h0000, q_cmd.ch};
                                seq_left_next = 2'd1;
                                state_next    = ST_ECHO;
                            end
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = seq_kind_reg;
                    out_data_next  = seq_reg[7:0];
                    out_last_next  = (seq_left_reg == 2'd1);
                    seq_next       = {8'h00, seq_reg[23:8]};
                    seq_left_next  = seq_left_reg - 2'd1;
                    if (seq_left_reg == 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD_ADDR:
            begin
                mem_re       = 1'b1;
                rp_next      = rp_inc;
                cc_next      = cc_reg - CW'(1);
                rd_left_next = rd_left_reg - 7'd1;
                state_next   = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tle_pkg::KIND_DATA;
                    out_data_next  = mem_rdata_reg;
                    out_last_next  = (rd_left_reg == 7'd0);
                    state_next     = (rd_left_reg == 7'd0) ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            tail_reg      <= '0;
            cc_reg        <= '0;
            el_reg        <= '0;
            seq_left_reg  <= 2'd0;
            rd_left_reg   <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            tail_reg      <= tail_next;
            cc_reg        <= cc_next;
            el_reg        <= el_next;
            seq_left_reg  <= seq_left_next;
            rd_left_reg   <= rd_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        seq_kind_reg <= seq_kind_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[tail_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= ring_mem[rp_reg];
        end
    end

    // committed plus edited bytes never overrun the ring
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= (CW+1)'(RING_BYTES))
        else $error("ring fill exceeds capacity");

    // edited line always leaves room for its newline
    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (EW+1)'(el_reg) < (EW+1)'(LINE_BYTES))
        else $error("edit length out of range");

    // write position tracks read pointer plus queued bytes, modulo ring size
    a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == ((pos_sum >= SW'(RING_BYTES)) ? AW'(pos_sum - SW'(RING_BYTES))
                                                   : AW'(pos_sum)))
        else $error("tail pointer out of step");

    // a ring read is only issued with committed bytes available
    a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ADDR) |-> (cc_reg != '0))
        else $error("ring read with nothing committed");

    // ring data word follows the read cycle
    a_read_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ADDR) |=> (state_reg == ST_RD_DATA))
        else $error("read data state skipped");

endmodule

`default_nettype wire
